FILE: hw/rtl/bra_pkg.sv
// ----------------------------------------------------------------------------
// bra_pkg
// Shared types and constants for the byte register ALU with skip.
// ----------------------------------------------------------------------------
package bra_pkg;

    localparam int unsigned RegCount = 16;
    localparam int unsigned IdxWidth = 4;
    localparam int unsigned DataWidth = 8;
    localparam logic [IdxWidth-1:0] FlagIdx = 4'hF;

    localparam logic [3:0] OP_SKIP_EQ_IMM = 4'h3;
    localparam logic [3:0] OP_SKIP_NE_IMM = 4'h4;
    localparam logic [3:0] OP_SKIP_EQ_REG = 4'h5;
    localparam logic [3:0] OP_LOAD_IMM    = 4'h6;
    localparam logic [3:0] OP_ADD_IMM     = 4'h7;
    localparam logic [3:0] OP_ALU         = 4'h8;
    localparam logic [3:0] OP_SKIP_NE_REG = 4'h9;

    localparam logic [3:0] SUB_MOV  = 4'h0;
    localparam logic [3:0] SUB_OR   = 4'h1;
    localparam logic [3:0] SUB_AND  = 4'h2;
    localparam logic [3:0] SUB_XOR  = 4'h3;
    localparam logic [3:0] SUB_ADD  = 4'h4;
    localparam logic [3:0] SUB_SUB  = 4'h5;
    localparam logic [3:0] SUB_SHR  = 4'h6;
    localparam logic [3:0] SUB_SUBN = 4'h7;
    localparam logic [3:0] SUB_SHL  = 4'hE;

    typedef struct packed {
        logic                 skip_next;
        logic [DataWidth-1:0] dest_value;
        logic                 dest_written;
        logic                 flag_value;
        logic                 flag_written;
        logic                 invalid;
    } res_t;

    typedef struct packed {
        logic                 x_en;
        logic [IdxWidth-1:0]  x_idx;
        logic [DataWidth-1:0] x_val;
        logic                 f_en;
        logic                 f_val;
    } wr_t;

endpackage

FILE: hw/rtl/bra_cmd_if.sv
// ----------------------------------------------------------------------------
// bra_cmd_if
// Instruction channel carrying one decoded instruction per transaction.
// ----------------------------------------------------------------------------
interface bra_cmd_if;
    logic       valid;
    logic       ready;
    logic [3:0] opcode;
    logic [3:0] x_index;
    logic [3:0] y_index;
    logic [7:0] immediate;

    modport source (output valid, output opcode, output x_index, output y_index,
                    output immediate, input ready);
    modport sink (input valid, input opcode, input x_index, input y_index,
                  input immediate, output ready);
endinterface

FILE: hw/rtl/bra_res_if.sv
// ----------------------------------------------------------------------------
// bra_res_if
// Result channel carrying the outcome of one instruction per transaction.
// ----------------------------------------------------------------------------
interface bra_res_if;
    logic       valid;
    logic       ready;
    logic       skip_next;
    logic [7:0] dest_value;
    logic       dest_written;
    logic       flag_value;
    logic       flag_written;
    logic       invalid;

    modport source (output valid, output skip_next, output dest_value,
                    output dest_written, output flag_value, output flag_written,
                    output invalid, input ready);
    modport sink (input valid, input skip_next, input dest_value,
                  input dest_written, input flag_value, input flag_written,
                  input invalid, output ready);
endinterface

FILE: hw/rtl/bra_regfile.sv
// ----------------------------------------------------------------------------
// bra_regfile
// Register file: registers 0 to 14 in a memory with registered reads and
// valid bits, register 15 in its own flip-flops, and a bypass for a write
// that lands in the same cycle as a read.
// ----------------------------------------------------------------------------
module bra_regfile (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rd_en,
    input  logic [bra_pkg::IdxWidth-1:0]      rd_x_idx,
    input  logic [bra_pkg::IdxWidth-1:0]      rd_y_idx,
    input  bra_pkg::wr_t                      wr,
    output logic [bra_pkg::DataWidth-1:0]     vx,
    output logic [bra_pkg::DataWidth-1:0]     vy
);

    localparam int unsigned MemDepth = bra_pkg::RegCount - 1;

    logic [bra_pkg::DataWidth-1:0] mem [0:MemDepth-1];
    logic [MemDepth-1:0]           valid_reg;
    logic [bra_pkg::DataWidth-1:0] v15_reg;

    logic [bra_pkg::DataWidth-1:0] rdx_data_reg;
    logic [bra_pkg::DataWidth-1:0] rdy_data_reg;
    logic                          rdx_valid_reg;
    logic                          rdy_valid_reg;
    logic [bra_pkg::IdxWidth-1:0]  rdx_idx_reg;
    logic [bra_pkg::IdxWidth-1:0]  rdy_idx_reg;

    logic                          byp_en_reg;
    logic [bra_pkg::IdxWidth-1:0]  byp_idx_reg;
    logic [bra_pkg::DataWidth-1:0] byp_val_reg;

    logic mem_wen;

    assign mem_wen = wr.x_en && (wr.x_idx != bra_pkg::FlagIdx);

    always_ff @(posedge clk)
    begin
        if (mem_wen)
        begin
            mem[wr.x_idx] <= wr.x_val;
        end
        if (rd_en && (rd_x_idx != bra_pkg::FlagIdx))
        begin
            rdx_data_reg <= mem[rd_x_idx];
        end
        if (rd_en && (rd_y_idx != bra_pkg::FlagIdx))
        begin
            rdy_data_reg <= mem[rd_y_idx];
        end
        if (rd_en)
        begin
            byp_idx_reg <= wr.x_idx;
            byp_val_reg <= wr.x_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            v15_reg       <= '0;
            rdx_valid_reg <= 1'b0;
            rdy_valid_reg <= 1'b0;
            rdx_idx_reg   <= '0;
            rdy_idx_reg   <= '0;
            byp_en_reg    <= 1'b0;
        end
        else
        begin
            if (mem_wen)
            begin
                valid_reg[wr.x_idx] <= 1'b1;
            end
            if (wr.f_en)
            begin
                v15_reg <= {{(bra_pkg::DataWidth-1){1'b0}}, wr.f_val};
            end
            else if (wr.x_en && (wr.x_idx == bra_pkg::FlagIdx))
            begin
                v15_reg <= wr.x_val;
            end
            if (rd_en)
            begin
                rdx_idx_reg   <= rd_x_idx;
                rdy_idx_reg   <= rd_y_idx;
                rdx_valid_reg <= (rd_x_idx != bra_pkg::FlagIdx) && valid_reg[rd_x_idx];
                rdy_valid_reg <= (rd_y_idx != bra_pkg::FlagIdx) && valid_reg[rd_y_idx];
                byp_en_reg    <= mem_wen;
            end
        end
    end

    always_comb
    begin
        if (rdx_idx_reg == bra_pkg::FlagIdx)
        begin
            vx = v15_reg;
        end
        else if (byp_en_reg && (byp_idx_reg == rdx_idx_reg))
        begin
            vx = byp_val_reg;
        end
        else if (rdx_valid_reg)
        begin
            vx = rdx_data_reg;
        end
        else
        begin
            vx = '0;
        end

        if (rdy_idx_reg == bra_pkg::FlagIdx)
        begin
            vy = v15_reg;
        end
        else if (byp_en_reg && (byp_idx_reg == rdy_idx_reg))
        begin
            vy = byp_val_reg;
        end
        else if (rdy_valid_reg)
        begin
            vy = rdy_data_reg;
        end
        else
        begin
            vy = '0;
        end
    end

endmodule

FILE: hw/rtl/bra_alu.sv
// ----------------------------------------------------------------------------
// bra_alu
// Decodes one instruction and computes its skip, destination value and flag.
// ----------------------------------------------------------------------------
module bra_alu (
    input  logic [3:0]                    opcode,
    input  logic [7:0]                    immediate,
    input  logic [bra_pkg::DataWidth-1:0] vx,
    input  logic [bra_pkg::DataWidth-1:0] vy,
    output bra_pkg::res_t                 res
);

    logic [3:0]                    sub;
    logic [bra_pkg::DataWidth:0]   sum;
    logic [bra_pkg::DataWidth-1:0] diff_xy;
    logic [bra_pkg::DataWidth-1:0] diff_yx;

    assign sub     = immediate[3:0];
    assign sum     = {1'b0, vx} + {1'b0, vy};
    assign diff_xy = vx - vy;
    assign diff_yx = vy - vx;

    always_comb
    begin
        res = '0;
        case (opcode)
            bra_pkg::OP_SKIP_EQ_IMM:
            begin
                res.skip_next = (vx == immediate);
            end
            bra_pkg::OP_SKIP_NE_IMM:
            begin
                res.skip_next = (vx != immediate);
            end
            bra_pkg::OP_SKIP_EQ_REG:
            begin
                if (sub == bra_pkg::SUB_MOV)
                begin
                    res.skip_next = (vx == vy);
                end
                else
                begin
                    res.invalid = 1'b1;
                end
            end
            bra_pkg::OP_SKIP_NE_REG:
            begin
                res.skip_next = (vx != vy);
            end
            bra_pkg::OP_LOAD_IMM:
            begin
                res.dest_value   = immediate;
                res.dest_written = 1'b1;
            end
            bra_pkg::OP_ADD_IMM:
            begin
                res.dest_value   = vx + immediate;
                res.dest_written = 1'b1;
            end
            bra_pkg::OP_ALU:
            begin
                res.dest_written = 1'b1;
                case (sub)
                    bra_pkg::SUB_MOV:
                    begin
                        res.dest_value = vy;
                    end
                    bra_pkg::SUB_OR:
                    begin
                        res.dest_value = vx | vy;
                    end
                    bra_pkg::SUB_AND:
                    begin
                        res.dest_value = vx & vy;
                    end
                    bra_pkg::SUB_XOR:
                    begin
                        res.dest_value = vx ^ vy;
                    end
                    bra_pkg::SUB_ADD:
                    begin
                        res.dest_value   = sum[bra_pkg::DataWidth-1:0];
                        res.flag_value   = sum[bra_pkg::DataWidth];
                        res.flag_written = 1'b1;
                    end
                    bra_pkg::SUB_SUB:
                    begin
                        res.dest_value   = diff_xy;
                        res.flag_value   = (vx >= vy);
                        res.flag_written = 1'b1;
                    end
                    bra_pkg::SUB_SHR:
                    begin
                        res.dest_value   = {1'b0, vx[bra_pkg::DataWidth-1:1]};
                        res.flag_value   = vx[0];
                        res.flag_written = 1'b1;
                    end
                    bra_pkg::SUB_SUBN:
                    begin
                        res.dest_value   = diff_yx;
                        res.flag_value   = (vy >= vx);
                        res.flag_written = 1'b1;
                    end
                    bra_pkg::SUB_SHL:
                    begin
                        res.dest_value   = {vx[bra_pkg::DataWidth-2:0], 1'b0};
                        res.flag_value   = vx[bra_pkg::DataWidth-1];
                        res.flag_written = 1'b1;
                    end
                    default:
                    begin
                        res.dest_written = 1'b0;
                        res.invalid      = 1'b1;
                    end
                endcase
            end
            default:
            begin
                res.invalid = 1'b1;
            end
        endcase
    end

endmodule

FILE: hw/rtl/byte_register_alu_skip_top.sv
// ----------------------------------------------------------------------------
// byte_register_alu_skip_top
// Register and arithmetic execute unit of a 16-register, 8-bit machine.
// ----------------------------------------------------------------------------
// The unit takes one instruction transaction per clock unless a waiting result
// holds it, and returns one result transaction for each, in order. An accepted
// instruction sits in the input register while its register operands are
// read, then the ALU result is captured in the output register, from which it
// is offered as a result transaction. Register writes land when an instruction
// leaves the input register and are forwarded to the instruction behind it,
// so back-to-back dependent instructions run at full rate. The input register
// and the output register together let a new instruction enter while an
// earlier result still waits to be taken. After reset all registers read 0.
module byte_register_alu_skip_top (
    input  logic         clk,
    input  logic         rst_n,
    bra_cmd_if.sink      cmd,
    bra_res_if.source    res
);

    logic                         in_valid_reg;
    logic [3:0]                   opcode_reg;
    logic [bra_pkg::IdxWidth-1:0] x_idx_reg;
    logic [7:0]                   immediate_reg;

    logic                         out_valid_reg;
    bra_pkg::res_t                res_reg;

    logic                          accept;
    logic                          advance;
    logic [bra_pkg::DataWidth-1:0] vx;
    logic [bra_pkg::DataWidth-1:0] vy;
    bra_pkg::res_t                 alu_res;
    bra_pkg::wr_t                  wr;

    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign accept    = cmd.valid && cmd.ready;

    assign wr.x_en  = advance && alu_res.dest_written;
    assign wr.x_idx = x_idx_reg;
    assign wr.x_val = alu_res.dest_value;
    assign wr.f_en  = advance && alu_res.flag_written;
    assign wr.f_val = alu_res.flag_value;

    bra_regfile u_regfile (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_x_idx (cmd.x_index),
        .rd_y_idx (cmd.y_index),
        .wr       (wr),
        .vx       (vx),
        .vy       (vy)
    );

    bra_alu u_alu (
        .opcode    (opcode_reg),
        .immediate (immediate_reg),
        .vx        (vx),
        .vy        (vy),
        .res       (alu_res)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            opcode_reg    <= cmd.opcode;
            x_idx_reg     <= cmd.x_index;
            immediate_reg <= cmd.immediate;
        end
        if (advance)
        begin
            res_reg <= alu_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.skip_next    = res_reg.skip_next;
    assign res.dest_value   = res_reg.dest_value;
    assign res.dest_written = res_reg.dest_written;
    assign res.flag_value   = res_reg.flag_value;
    assign res.flag_written = res_reg.flag_written;
    assign res.invalid      = res_reg.invalid;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the byte register ALU with skip. A local model
// of the register file predicts every result, and a checker compares each
// result transaction field by field. Directed tests cover the arithmetic
// extremes, the compares, the invalid codes and the flag register as a
// destination. Random traffic follows, with random gaps on both channels, a
// long result stall and a pause until every result has drained.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [3:0] OP_SYS        = 4'h0;
    localparam logic [3:0] OP_LOAD_INDEX = 4'hA;
    localparam logic [3:0] OP_KEY_TIMER  = 4'hF;
    localparam logic [3:0] SKIP_REG_SUB  = 4'h0;
    localparam logic [3:0] SUB_UNDEF_LO  = 4'h8;
    localparam logic [3:0] SUB_UNDEF_HI  = 4'hF;

    localparam int LONG_HOLD      = 48;
    localparam int WATCHDOG_LIMIT = 1000;

    logic clk;
    logic rst_n;

    bra_cmd_if cmd_ch ();
    bra_res_if res_ch ();

    byte_register_alu_skip_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    logic [7:0]     gpr [bra_pkg::RegCount];
    bra_pkg::res_t  pending_results [$];

    bit idle_enable;
    bit hold_request;
    int error_count;
    int instr_count;
    int skip_count;
    int flag_count;
    int invalid_count;
    int stall_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic bra_pkg::res_t alu_execute(logic [3:0] op, logic [3:0] x,
                                                  logic [3:0] y, logic [7:0] imm);
        bra_pkg::res_t r;
        logic [7:0]    vx;
        logic [7:0]    vy;
        logic [8:0]    sum;
        r   = '0;
        vx  = gpr[x];
        vy  = gpr[y];
        sum = {1'b0, vx} + {1'b0, vy};
        case (op)
            bra_pkg::OP_SKIP_EQ_IMM: r.skip_next = (vx == imm);
            bra_pkg::OP_SKIP_NE_IMM: r.skip_next = (vx != imm);
            bra_pkg::OP_SKIP_EQ_REG:
            begin
                if (imm[3:0] == SKIP_REG_SUB)
                    r.skip_next = (vx == vy);
                else
                    r.invalid = 1'b1;
            end
            bra_pkg::OP_LOAD_IMM:
            begin
                r.dest_value   = imm;
                r.dest_written = 1'b1;
            end
            bra_pkg::OP_ADD_IMM:
            begin
                r.dest_value   = vx + imm;
                r.dest_written = 1'b1;
            end
            bra_pkg::OP_ALU:
            begin
                r.dest_written = 1'b1;
                r.flag_written = 1'b1;
                case (imm[3:0])
                    bra_pkg::SUB_MOV:
                    begin
                        r.dest_value   = vy;
                        r.flag_written = 1'b0;
                    end
                    bra_pkg::SUB_OR:
                    begin
                        r.dest_value   = vx | vy;
                        r.flag_written = 1'b0;
                    end
                    bra_pkg::SUB_AND:
                    begin
                        r.dest_value   = vx & vy;
                        r.flag_written = 1'b0;
                    end
                    bra_pkg::SUB_XOR:
                    begin
                        r.dest_value   = vx ^ vy;
                        r.flag_written = 1'b0;
                    end
                    bra_pkg::SUB_ADD:
                    begin
                        r.dest_value = sum[7:0];
                        r.flag_value = sum[8];
                    end
                    bra_pkg::SUB_SUB:
                    begin
                        r.dest_value = vx - vy;
                        r.flag_value = (vx >= vy);
                    end
                    bra_pkg::SUB_SHR:
                    begin
                        r.dest_value = vx >> 1;
                        r.flag_value = vx[0];
                    end
                    bra_pkg::SUB_SUBN:
                    begin
                        r.dest_value = vy - vx;
                        r.flag_value = (vy >= vx);
                    end
                    bra_pkg::SUB_SHL:
                    begin
                        r.dest_value = vx << 1;
                        r.flag_value = vx[7];
                    end
                    default:
                    begin
                        r = '0;
                        r.invalid = 1'b1;
                    end
                endcase
            end
            bra_pkg::OP_SKIP_NE_REG: r.skip_next = (vx != vy);
            default: r.invalid = 1'b1;
        endcase
        if (r.dest_written)
            gpr[x] = r.dest_value;
        if (r.flag_written)
            gpr[bra_pkg::FlagIdx] = {7'b0, r.flag_value};
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_enable)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [3:0] pick_reg();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 4'($urandom_range(0, 3));
        if (r == 5)
            return bra_pkg::FlagIdx;
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic logic [3:0] pick_alu_sub();
        case ($urandom_range(0, 8))
            0: return bra_pkg::SUB_MOV;
            1: return bra_pkg::SUB_OR;
            2: return bra_pkg::SUB_AND;
            3: return bra_pkg::SUB_XOR;
            4: return bra_pkg::SUB_ADD;
            5: return bra_pkg::SUB_SUB;
            6: return bra_pkg::SUB_SHR;
            7: return bra_pkg::SUB_SUBN;
            default: return bra_pkg::SUB_SHL;
        endcase
    endfunction

    task automatic report_error(string msg);
        error_count++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_error($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // The valid is left high on return; the next call either replaces the
    // transaction in the same time step or lowers it for a gap.
    task automatic send_instr(logic [3:0] op, logic [3:0] x, logic [3:0] y, logic [7:0] imm);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.opcode    <= op;
        cmd_ch.x_index   <= x;
        cmd_ch.y_index   <= y;
        cmd_ch.immediate <= imm;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        pending_results.push_back(alu_execute(op, x, y, imm));
        instr_count++;
    endtask

    task automatic send_random_instr();
        logic [3:0] op;
        logic [3:0] x;
        logic [3:0] y;
        logic [7:0] imm;
        x   = pick_reg();
        y   = pick_reg();
        imm = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 10)
        begin
            op = 4'($urandom_range(0, 15));
            x  = 4'($urandom_range(0, 15));
            y  = 4'($urandom_range(0, 15));
        end
        else
        begin
            case ($urandom_range(0, 9))
                0: op = bra_pkg::OP_LOAD_IMM;
                1: op = bra_pkg::OP_ADD_IMM;
                2, 3:
                begin
                    op = $urandom_range(0, 1) ? bra_pkg::OP_SKIP_EQ_IMM
                                              : bra_pkg::OP_SKIP_NE_IMM;
                    if ($urandom_range(0, 1))
                        imm = gpr[x];
                end
                4:
                begin
                    op       = bra_pkg::OP_SKIP_EQ_REG;
                    imm[3:0] = SKIP_REG_SUB;
                end
                5: op = bra_pkg::OP_SKIP_NE_REG;
                default:
                begin
                    op       = bra_pkg::OP_ALU;
                    imm[3:0] = pick_alu_sub();
                end
            endcase
        end
        send_instr(op, x, y, imm);
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_arith_extremes();
        send_instr(bra_pkg::OP_LOAD_IMM, 4'd0, 4'd0, 8'hFF);
        send_instr(bra_pkg::OP_LOAD_IMM, 4'd1, 4'd0, 8'h01);
        send_instr(bra_pkg::OP_ALU, 4'd0, 4'd1, {4'h0, bra_pkg::SUB_ADD});
        send_instr(bra_pkg::OP_ADD_IMM, 4'd0, 4'd0, 8'hFF);
        send_instr(bra_pkg::OP_ALU, 4'd1, 4'd0, {4'hF, bra_pkg::SUB_SUB});
        send_instr(bra_pkg::OP_ALU, 4'd0, 4'd1, {4'hA, bra_pkg::SUB_SUBN});
        send_instr(bra_pkg::OP_ALU, 4'd0, 4'd0, {4'h5, bra_pkg::SUB_SHR});
        send_instr(bra_pkg::OP_LOAD_IMM, 4'd2, 4'd0, 8'h80);
        send_instr(bra_pkg::OP_ALU, 4'd2, 4'd2, {4'h0, bra_pkg::SUB_SHL});
        send_instr(bra_pkg::OP_ALU, 4'd3, 4'd1, {4'h0, bra_pkg::SUB_MOV});
        send_instr(bra_pkg::OP_ALU, 4'd3, 4'd0, {4'h0, bra_pkg::SUB_OR});
        send_instr(bra_pkg::OP_ALU, 4'd3, 4'd1, {4'h0, bra_pkg::SUB_AND});
        send_instr(bra_pkg::OP_ALU, 4'd3, 4'd0, {4'h0, bra_pkg::SUB_XOR});
    endtask

    task automatic test_compare_skip();
        send_instr(bra_pkg::OP_SKIP_EQ_IMM, 4'd1, 4'd0, gpr[1]);
        send_instr(bra_pkg::OP_SKIP_NE_IMM, 4'd1, 4'd0, gpr[1]);
        send_instr(bra_pkg::OP_SKIP_NE_IMM, 4'd1, 4'd0, ~gpr[1]);
        send_instr(bra_pkg::OP_SKIP_EQ_REG, 4'd1, 4'd1, {4'hF, SKIP_REG_SUB});
        send_instr(bra_pkg::OP_SKIP_NE_REG, 4'd0, 4'd1, 8'hFF);
    endtask

    task automatic test_invalid_codes();
        send_instr(OP_SYS, 4'd0, 4'd1, 8'hE0);
        send_instr(OP_LOAD_INDEX, 4'd5, 4'd2, 8'h12);
        send_instr(OP_KEY_TIMER, 4'hF, 4'hF, 8'hFF);
        send_instr(bra_pkg::OP_ALU, 4'd0, 4'd1, {4'h0, SUB_UNDEF_LO});
        send_instr(bra_pkg::OP_ALU, 4'd0, 4'd1, {4'h3, SUB_UNDEF_HI});
        send_instr(bra_pkg::OP_SKIP_EQ_REG, 4'd1, 4'd1, {4'h0, SUB_UNDEF_HI});
    endtask

    task automatic test_flag_register_dest();
        send_instr(bra_pkg::OP_LOAD_IMM, bra_pkg::FlagIdx, 4'd0, 8'hFF);
        send_instr(bra_pkg::OP_ALU, bra_pkg::FlagIdx, bra_pkg::FlagIdx,
                   {4'h0, bra_pkg::SUB_ADD});
        send_instr(bra_pkg::OP_ALU, 4'd1, 4'd1, {4'h0, bra_pkg::SUB_SUB});
    endtask

    task automatic test_random_traffic(int count, bit with_idle);
        idle_enable = with_idle;
        repeat (count) send_random_instr();
    endtask

    task automatic test_backpressure();
        idle_enable  = 1'b0;
        hold_request = 1'b1;
        repeat (60) send_random_instr();
    endtask

    task automatic test_drain_pause();
        idle_enable = 1'b1;
        repeat (40) send_random_instr();
        wait_drained();
        repeat (40) send_random_instr();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.opcode    = '0;
        cmd_ch.x_index   = '0;
        cmd_ch.y_index   = '0;
        cmd_ch.immediate = '0;
        idle_enable      = 1'b1;
        hold_request     = 1'b0;
        for (int i = 0; i < bra_pkg::RegCount; i++)
            gpr[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_arith_extremes();
        test_compare_skip();
        test_invalid_codes();
        test_flag_register_dest();
        wait_drained();
        test_random_traffic(300, 1'b1);
        test_random_traffic(150, 1'b0);
        test_backpressure();
        test_drain_pause();
        test_random_traffic(520, 1'b1);

        wait_drained();
        repeat (5) @(posedge clk);
        $display("Executed %0d instructions: %0d skips, %0d flag writes, %0d invalid.",
                 instr_count, skip_count, flag_count, invalid_count);
        $display("Traffic mixed random gaps on both sides, %0d cycles of result stall %s",
                 stall_cycles, "and a full drain pause.");
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int ready_gap;
        int hold_left;
        res_ch.ready = 1'b0;
        ready_gap    = 0;
        hold_left    = 0;
        stall_cycles = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request && hold_left == 0)
            begin
                hold_left    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_cycles++;
                res_ch.ready <= 1'b0;
            end
            else if (ready_gap > 0)
            begin
                ready_gap--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                ready_gap = pick_gap();
                res_ch.ready <= (ready_gap == 0);
                if (ready_gap > 0)
                    ready_gap--;
            end
        end
    end

    always @(posedge clk)
    begin
        bra_pkg::res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_error("result transaction with no instruction outstanding");
            else
            begin
                want = pending_results.pop_front();
                check_field("skip_next", res_ch.skip_next, want.skip_next);
                check_field("dest_value", res_ch.dest_value, want.dest_value);
                check_field("dest_written", res_ch.dest_written, want.dest_written);
                check_field("flag_value", res_ch.flag_value, want.flag_value);
                check_field("flag_written", res_ch.flag_written, want.flag_written);
                check_field("invalid", res_ch.invalid, want.invalid);
                skip_count    += want.skip_next;
                flag_count    += want.flag_written;
                invalid_count += want.invalid;
            end
        end
    end

    always @(posedge clk)
    begin
        int idle_cycles;
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d results outstanding.", pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
